[hdl/tccw_pkg.sv]
`default_nettype none

package tccw_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ATTR = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_ROWS = 2'd2;

  // Register values after reset.
  localparam logic [7:0] ATTR_RESET = 8'd15;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd25;

  // Character codes with special handling.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_STEP = 8;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // What a put request asks of the controller.
  typedef struct packed {
    logic do_write;
    logic do_scroll;
  } put_flags_t;

endpackage

`default_nettype wire

[hdl/tccw_ram.sv]
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tccw_cursor.sv]
`default_nettype none

module tccw_cursor #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32,
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int NCW = $clog2(MAX_COLS + 1),
  localparam int NRW = $clog2(MAX_ROWS + 1),
  localparam int AW  = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  wire logic [CW-1:0]     cur_col,
  input  wire logic [RW-1:0]     cur_row,
  input  wire logic [NCW-1:0]    nc,
  input  wire logic [NRW-1:0]    nr,
  input  wire logic [7:0]        char_code,
  output logic      [CW-1:0]     new_col,
  output logic      [RW-1:0]     new_row,
  output logic      [AW-1:0]     put_addr,
  output tccw_pkg::put_flags_t   flags
);

  import tccw_pkg::*;

  localparam int LW = RW + NCW + 1;

  logic [CW-1:0] sat_col;
  logic [RW-1:0] sat_row;
  logic [CW:0]   col_w;
  logic [RW:0]   row_w;
  logic [CW:0]   tab_sum;
  logic [LW-1:0] lin;

  // A cursor left outside the screen by a register change is pulled in first.
  always_comb begin
    sat_col = (NCW'(cur_col) >= nc) ? CW'(nc - 1'b1) : cur_col;
    sat_row = (NRW'(cur_row) >= nr) ? RW'(nr - 1'b1) : cur_row;
  end

  // Cell written by a printable character.
  always_comb begin
    lin      = LW'(sat_row) * LW'(nc) + LW'(sat_col);
    put_addr = AW'(lin);
  end

  // Cursor motion for the byte, then wrap and scroll detection.
  always_comb begin
    col_w          = {1'b0, sat_col};
    row_w          = {1'b0, sat_row};
    tab_sum        = (CW+1)'(sat_col) + (CW+1)'(TAB_STEP);
    flags.do_write = 1'b0;
    case (char_code)
      CH_BS: begin
        if (sat_col != '0) begin
          col_w = {1'b0, sat_col} - 1'b1;
        end
      end
      CH_TAB: begin
        col_w = tab_sum & ~(CW+1)'(TAB_STEP - 1);
      end
      CH_CR: begin
        col_w = '0;
      end
      CH_LF: begin
        col_w = '0;
        row_w = {1'b0, sat_row} + 1'b1;
      end
      default: begin
        if (char_code >= CH_SPACE) begin
          flags.do_write = 1'b1;
          col_w          = {1'b0, sat_col} + 1'b1;
        end
      end
    endcase

    if (col_w >= (CW+1)'(nc)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end

    flags.do_scroll = (row_w >= (RW+1)'(nr));
    new_col         = CW'(col_w);
    new_row         = flags.do_scroll ? RW'(nr - 1'b1) : RW'(row_w);
  end

endmodule

`default_nettype wire

[hdl/text_console_char_writer_core.sv]
// Text console character writer.
//
// Requests arrive on the input channel (in_valid/in_ready) with req_type,
// char_code and cell_index; each accepted item yields exactly one result on the
// output channel (out_valid/out_ready) carrying the cursor after the request and,
// for reads, the stored cell. Registers are written through
// cfg_we/cfg_index/cfg_data while the block is idle, which only the user ensures.
//
// Put, read and unused requests go from IDLE straight to FINISH: the item is
// accepted, and the result is loaded into the output register once it is free.
// A clear, or a put that passes the last row, walks the screen memory one
// cell per cycle through the single write port.
// Scrolling copies each cell from the row below through the registered read
// port, one read and one write per cycle.
//
// After reset the screen memory is cleared to zero, one cell per cycle, before
// the first item is accepted. A stalled receiver holds the result in the output
// register; the block then accepts one more item and waits before loading
// its result.
`default_nettype none

module text_console_char_writer_core #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  char_code,
  input  wire logic [11:0] cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [6:0]  cursor_col,
  output logic      [4:0]  cursor_row,
  output logic      [11:0] cursor_offset,
  output logic      [15:0] read_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  import tccw_pkg::*;

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int TW  = AW + 1;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int NCW = $clog2(MAX_COLS + 1);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int OW  = RW + NCW + 1;

  state_t state, state_next;

  logic [7:0] text_attribute;
  logic [7:0] columns;
  logic [5:0] rows;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;

  logic [NCW-1:0] nc;
  logic [NRW-1:0] nr;

  logic [CW-1:0] new_col;
  logic [RW-1:0] new_row;
  logic [AW-1:0] put_addr;
  put_flags_t    put_flags;

  logic          sweep_copy;
  logic          sweep_zero;
  logic [TW-1:0] total;
  logic [TW-1:0] idx;
  logic [TW-1:0] copy_len;
  logic [TW-1:0] src_sum;

  logic          wr_valid;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          wr_from_ram;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [15:0]   ram_wdata;

  logic          in_fire;
  logic          rd_hit_in;
  logic          is_read;
  logic          issue;
  logic          issue_copy;
  logic          load_out;
  logic [OW-1:0] off_full;

  // Effective screen size: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (columns == '0) begin
      nc = NCW'(1);
    end else if (int'(columns) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(columns);
    end
    if (rows == '0) begin
      nr = NRW'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows);
    end
  end

  // Sweep bounds: a scroll copies all rows but the last, clear and init copy none.
  always_comb begin
    copy_len  = sweep_copy ? (total - TW'(nc)) : '0;
    src_sum   = idx + TW'(nc);
    rd_hit_in = (int'(cell_index) < CELL_COUNT);
    in_fire   = in_valid && in_ready;
    load_out  = (state == ST_FINISH) && (!out_valid || out_ready);
    off_full  = OW'(cur_row) * OW'(nc) + OW'(cur_col);
    ram_wdata = wr_from_ram ? ram_rdata : wr_data;
  end

  tccw_cursor #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cursor (
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .nc        (nc),
    .nr        (nr),
    .char_code (char_code),
    .new_col   (new_col),
    .new_row   (new_row),
    .put_addr  (put_addr),
    .flags     (put_flags)
  );

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_valid),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_PUT:   state_next = put_flags.do_scroll ? ST_SETUP : ST_FINISH;
            REQ_CLEAR: state_next = ST_SETUP;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_SETUP: begin
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (idx >= total) begin
          state_next = sweep_zero ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller outputs: handshake and memory read port.
  always_comb begin
    in_ready   = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = AW'(cell_index);
    issue      = 1'b0;
    issue_copy = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_valid && (req_type == REQ_READ) && rd_hit_in;
      end
      ST_SWEEP: begin
        if (idx < total) begin
          issue = 1'b1;
          if (idx < copy_len) begin
            issue_copy = 1'b1;
            ram_re     = 1'b1;
            ram_raddr  = src_sum[AW-1:0];
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_SWEEP;
      sweep_zero     <= 1'b1;
      sweep_copy     <= 1'b0;
      total          <= TW'(CELL_COUNT);
      idx            <= '0;
      wr_valid       <= 1'b0;
      out_valid      <= 1'b0;
      cur_col        <= '0;
      cur_row        <= '0;
      text_attribute <= ATTR_RESET;
      columns        <= COLS_RESET;
      rows           <= ROWS_RESET;
    end else begin
      state    <= state_next;
      wr_valid <= 1'b0;

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTR: text_attribute <= cfg_data;
          CFG_COLS: columns        <= cfg_data;
          CFG_ROWS: rows           <= cfg_data[5:0];
          default:  ;
        endcase
      end

      // Request start.
      if (in_fire) begin
        case (req_type)
          REQ_PUT: begin
            cur_col    <= new_col;
            cur_row    <= new_row;
            wr_valid   <= put_flags.do_write;
            sweep_copy <= 1'b1;
            sweep_zero <= 1'b0;
          end
          REQ_CLEAR: begin
            cur_col    <= '0;
            cur_row    <= '0;
            sweep_copy <= 1'b0;
            sweep_zero <= 1'b0;
          end
          default: ;
        endcase
      end

      // Sweep size, then one cell per cycle.
      if (state == ST_SETUP) begin
        total <= TW'(TW'(nc) * TW'(nr));
        idx   <= '0;
      end
      if (issue) begin
        idx      <= idx + 1'b1;
        wr_valid <= 1'b1;
      end

      // Output register.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_read     <= (req_type == REQ_READ) && rd_hit_in;
      wr_addr     <= put_addr;
      wr_data     <= {text_attribute, char_code};
      wr_from_ram <= 1'b0;
    end
    if (issue) begin
      wr_addr     <= idx[AW-1:0];
      wr_from_ram <= issue_copy;
      wr_data     <= sweep_zero ? 16'h0000 : {text_attribute, CH_SPACE};
    end
    if (load_out) begin
      cursor_col    <= 7'(cur_col);
      cursor_row    <= 5'(cur_row);
      cursor_offset <= 12'(off_full);
      read_data     <= is_read ? ram_rdata : 16'h0000;
    end
  end

  // A copied cell is written only right after its read was issued.
  a_copy_follows_read: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && wr_from_ram) |-> $past(ram_re))
    else $error("copy write without a preceding read");

  // The read and write ports never address the same cell in one cycle.
  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && ram_re) |-> (ram_raddr != wr_addr))
    else $error("read and write to the same cell in one cycle");

  // After a put the cursor lies inside the screen in use.
  a_put_cursor_inside: assert property (@(posedge clk) disable iff (rst)
    $past(in_fire && (req_type == REQ_PUT))
      |-> ((NCW'(cur_col) < $past(nc)) && (NRW'(cur_row) < $past(nr))))
    else $error("cursor outside the screen after a put");

endmodule

`default_nettype wire

[test/text_console_char_writer_core_tb.sv]
module text_console_char_writer_core_tb;
  import tccw_pkg::*;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 29;

  // Codes the package leaves unnamed.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // What one request reports back.
  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [11:0] offset;
    logic [15:0] data;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_PUT;
  logic [7:0]  char_code = '0;
  logic [11:0] cell_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [11:0] cursor_offset;
  logic [15:0] read_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ATTR;
  logic [7:0]  cfg_data = '0;

  // Shadow copy of the console used to work out each report.
  logic [15:0]    shadow_screen [CELL_TOTAL];
  int unsigned    shadow_col;
  int unsigned    shadow_row;
  logic [7:0]     shadow_attr;
  logic [7:0]     shadow_cols;
  logic [5:0]     shadow_rows;
  cursor_report_t pending_reports [$];
  cursor_report_t oldest_report;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;
  bit          hold_off_request = 1'b0;

  text_console_char_writer_core #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .char_code    (char_code),
    .cell_index   (cell_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .cursor_offset(cursor_offset),
    .read_data    (read_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Width and height in use, with out-of-range settings pinned to the limits.
  function automatic int unsigned used_cols();
    if (shadow_cols == 0) return 1;
    if (shadow_cols > MAX_COLS) return MAX_COLS;
    return shadow_cols;
  endfunction

  function automatic int unsigned used_rows();
    if (shadow_rows == 0) return 1;
    if (shadow_rows > MAX_ROWS) return MAX_ROWS;
    return shadow_rows;
  endfunction

  // Applies one request to the shadow console and returns its report.
  function automatic cursor_report_t console_step(input logic [1:0] req,
                                                  input logic [7:0] ch,
                                                  input logic [11:0] cell_pos);
    int unsigned    nc;
    int unsigned    nr;
    int unsigned    pos;
    cursor_report_t rep;
    nc = used_cols();
    nr = used_rows();
    rep.data = '0;
    case (req)
      REQ_PUT: begin
        // A cursor left outside a shrunken screen is pulled back first.
        if (shadow_col >= nc) shadow_col = nc - 1;
        if (shadow_row >= nr) shadow_row = nr - 1;
        if (ch == CH_BS) begin
          if (shadow_col != 0) shadow_col--;
        end else if (ch == CH_TAB) begin
          shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          shadow_col = 0;
        end else if (ch == CH_LF) begin
          shadow_col = 0;
          shadow_row++;
        end else if (ch >= CH_SPACE) begin
          shadow_screen[shadow_row * nc + shadow_col] = {shadow_attr, ch};
          shadow_col++;
        end
        if (shadow_col >= nc) begin
          shadow_col = 0;
          shadow_row++;
        end
        // Past the last row: move everything up one row and blank the bottom.
        if (shadow_row >= nr) begin
          for (int unsigned i = 0; i + nc < nc * nr; i++) begin
            shadow_screen[i] = shadow_screen[i + nc];
          end
          for (int unsigned i = (nr - 1) * nc; i < nr * nc; i++) begin
            shadow_screen[i] = {shadow_attr, CH_SPACE};
          end
          shadow_row = nr - 1;
        end
      end
      REQ_CLEAR: begin
        for (int unsigned i = 0; i < nc * nr; i++) begin
          shadow_screen[i] = {shadow_attr, CH_SPACE};
        end
        shadow_col = 0;
        shadow_row = 0;
      end
      REQ_READ: begin
        rep.data = shadow_screen[cell_pos];
      end
      default: begin
      end
    endcase
    rep.col = shadow_col[6:0];
    rep.row = shadow_row[4:0];
    pos = shadow_row * nc + shadow_col;
    rep.offset = pos[11:0];
    return rep;
  endfunction

  // Offers one item and records its expected report once it is taken.
  task automatic send_item(input logic [1:0] req, input logic [7:0] ch,
                           input logic [11:0] cell_pos);
    if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    char_code  <= ch;
    cell_index <= cell_pos;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(console_step(req, ch, cell_pos));
  endtask

  // Stops offering and waits until every report in flight has come back.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Rewrites the screen registers while the block is idle.
  task automatic set_screen(input logic [7:0] attr, input logic [7:0] cols,
                            input logic [7:0] rows_val, input bit poke_unused);
    wait_for_reports();
    while (!in_ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATTR;
    cfg_data  <= attr;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows_val;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow_attr = attr;
    shadow_cols = cols;
    shadow_rows = rows_val[5:0];
  endtask

  // Mostly printable text and cursor moves, with reads, clears and junk mixed in.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  req;
    logic [7:0]  ch;
    logic [11:0] cell_pos;
    pick     = $urandom_range(99);
    req      = REQ_PUT;
    ch       = 8'($urandom_range(255));
    cell_pos = 12'($urandom_range(CELL_TOTAL - 1));
    if (pick < 50) begin
      ch = 8'($urandom_range(255, CH_SPACE));
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0: ch = CH_BS;
        1: ch = CH_TAB;
        2: ch = CH_CR;
        default: ch = CH_LF;
      endcase
    end else if (pick < 74) begin
      ch = 8'($urandom_range(CH_SPACE - 1));
    end else if (pick < 90) begin
      req = REQ_READ;
      if ($urandom_range(3) != 0) begin
        cell_pos = 12'($urandom_range(used_cols() * used_rows() - 1));
      end
    end else if (pick < 93) begin
      req = REQ_CLEAR;
    end else if (pick < 96) begin
      req = REQ_UNUSED;
    end
    send_item(req, ch, cell_pos);
  endtask

  // Reads of the zeroed store, a first character and the unused request code.
  task automatic test_power_on_state();
    send_item(REQ_READ, 8'h00, 12'd0);
    send_item(REQ_READ, 8'h00, 12'hFFF);
    send_item(REQ_PUT, 8'h41, 12'h000);
    send_item(REQ_UNUSED, 8'hFF, 12'hABC);
  endtask

  // Highest byte, space, ignored control bytes and a read-back.
  task automatic test_character_codes();
    send_item(REQ_PUT, 8'hFF, 12'h000);
    send_item(REQ_PUT, CH_SPACE, 12'h000);
    send_item(REQ_PUT, 8'h00, 12'hFFF);
    send_item(REQ_PUT, 8'(CH_SPACE - 1), 12'h000);
    send_item(REQ_PUT, 8'h7F, 12'h000);
    send_item(REQ_READ, 8'h00, 12'd1);
  endtask

  // Return, backspace at the left edge and after a character, tabs, line feed.
  task automatic test_cursor_controls();
    send_item(REQ_PUT, CH_CR, 12'h000);
    send_item(REQ_PUT, CH_BS, 12'h000);
    send_item(REQ_PUT, 8'h78, 12'h000);
    send_item(REQ_PUT, CH_BS, 12'h000);
    send_item(REQ_PUT, CH_TAB, 12'h000);
    send_item(REQ_PUT, CH_TAB, 12'h000);
    send_item(REQ_PUT, CH_LF, 12'h000);
  endtask

  // Clear with the highest attribute; a cell beyond the screen stays as it was.
  task automatic test_clear_screen();
    set_screen(8'hFF, COLS_RESET, {2'b00, ROWS_RESET}, 1'b0);
    send_item(REQ_CLEAR, 8'h00, 12'h000);
    send_item(REQ_READ, 8'h00, 12'd0);
    send_item(REQ_READ, 8'h00, 12'd2000);
  endtask

  // Smallest and out-of-range sizes, then a cursor stranded by a shrink.
  task automatic test_screen_extremes();
    set_screen(8'h00, 8'd1, 8'd1, 1'b1);
    send_item(REQ_PUT, 8'h61, 12'h000);
    send_item(REQ_READ, 8'h00, 12'd0);
    set_screen(8'hA5, 8'd0, 8'd0, 1'b0);
    send_item(REQ_PUT, 8'h62, 12'h000);
    set_screen(8'h3C, 8'hFF, 8'h3F, 1'b0);
    send_item(REQ_PUT, CH_TAB, 12'h000);
    set_screen(ATTR_RESET, 8'd4, 8'd1, 1'b0);
    send_item(REQ_READ, 8'h00, 12'd3);
    send_item(REQ_PUT, 8'h7A, 12'h000);
  endtask

  // Random screen settings, mostly small, each with a run of random items.
  task automatic test_random_screens(input int unsigned item_total);
    int unsigned sent;
    int unsigned phase_len;
    logic [7:0]  cols_val;
    logic [7:0]  rows_val;
    sent = 0;
    while (sent < item_total) begin
      case ($urandom_range(19))
        0: cols_val = 8'd0;
        1: cols_val = 8'(MAX_COLS);
        2: cols_val = 8'($urandom_range(255, MAX_COLS + 1));
        default: cols_val = 8'($urandom_range(24, 1));
      endcase
      case ($urandom_range(19))
        0: rows_val = 8'd0;
        1: rows_val = 8'(MAX_ROWS);
        2: rows_val = 8'($urandom_range(63, MAX_ROWS + 1));
        default: rows_val = 8'($urandom_range(6, 1));
      endcase
      rows_val[7:6] = 2'($urandom_range(3));
      set_screen(8'($urandom_range(255)), cols_val, rows_val, $urandom_range(9) == 0);
      // Big screens make every clear and scroll slow, so keep those runs short.
      phase_len = (used_cols() * used_rows() > 512) ? 16 : $urandom_range(80, 30);
      repeat (phase_len) send_random_item();
      sent += phase_len;
    end
  endtask

  // Both sides run flat out with no idle cycles.
  task automatic test_back_to_back(input int unsigned item_total);
    set_screen(8'($urandom_range(255)), 8'd12, 8'd3, 1'b0);
    idle_on = 1'b0;
    repeat (item_total) send_random_item();
    idle_on = 1'b1;
  endtask

  // The receiver holds off long enough to fill the block, then the sender pauses.
  task automatic test_output_hold_off();
    set_screen(8'($urandom_range(255)), 8'd8, 8'd4, 1'b0);
    hold_off_request = 1'b1;
    repeat (40) send_random_item();
    wait_for_reports();
    repeat (40) send_random_item();
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Each report that leaves the block is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with nothing expected: col %0d row %0d offset %0d data %h",
               cursor_col, cursor_row, cursor_offset, read_data);
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        if (cursor_col !== oldest_report.col) begin
          $error("cursor_col expected %0d actual %0d", oldest_report.col, cursor_col);
          mismatches++;
        end
        if (cursor_row !== oldest_report.row) begin
          $error("cursor_row expected %0d actual %0d", oldest_report.row, cursor_row);
          mismatches++;
        end
        if (cursor_offset !== oldest_report.offset) begin
          $error("cursor_offset expected %0d actual %0d",
                 oldest_report.offset, cursor_offset);
          mismatches++;
        end
        if (read_data !== oldest_report.data) begin
          $error("read_data expected %h actual %h", oldest_report.data, read_data);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("text_console_char_writer_core: mismatch");
    $finish;
  end

  initial begin
    foreach (shadow_screen[i]) shadow_screen[i] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;
    shadow_cols = COLS_RESET;
    shadow_rows = ROWS_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_power_on_state();
    test_character_codes();
    test_cursor_controls();
    test_clear_screen();
    test_screen_extremes();
    test_random_screens(1300);
    test_back_to_back(300);
    test_output_hold_off();

    // Let the last reports arrive, then wait out a quiet drain period.
    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_char_writer_core: match");
    end else begin
      $display("text_console_char_writer_core: mismatch");
    end
    $finish;
  end

endmodule
